FILE: design/pfc_pkg.sv
// ============================================================================
// pfc_pkg - shared types and helpers for the Playfair digraph cipher
// Letter codes, pair descriptors and key-square lookup functions.
// ============================================================================
`default_nettype none

package pfc_pkg;

    localparam int LETTER_W   = 5;
    localparam int SQ_SIDE    = 5;
    localparam int SQ_CELLS   = SQ_SIDE * SQ_SIDE;
    localparam int SQ_W       = SQ_CELLS * LETTER_W;
    localparam int POS_W      = 3;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 45;
    localparam int PART_A_W   = 45;
    localparam int PART_B_W   = 40;
    localparam int PART_C_W   = 40;
    localparam int TDATA_W    = 8;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [SQ_W-1:0]     t_square;

    localparam t_letter CODE_FILLER = t_letter'(23);
    localparam t_letter CODE_SPACE  = t_letter'(26);
    localparam t_letter CODE_J      = t_letter'(9);
    localparam t_letter CODE_I      = t_letter'(8);

    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PART_A  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PART_B  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PART_C  = 2'd3;

    // One digraph waiting for substitution.
    typedef struct packed {
        t_letter first;
        t_letter second;
        logic    last;
    } t_pair;

    // Substituted digraph.
    typedef struct packed {
        t_letter o1;
        t_letter o2;
    } t_subst;

    typedef struct packed {
        t_pos row;
        t_pos col;
    } t_rowcol;

    // First cell in row-major order that holds the letter; row 0, col 0 if none.
    function automatic t_rowcol locate(input t_square sq, input t_letter letter);
        t_rowcol rc;
        rc.row = '0;
        rc.col = '0;
        for (int k = SQ_CELLS - 1; k >= 0; k--) begin
            if (sq[k*LETTER_W +: LETTER_W] == letter) begin
                rc.row = t_pos'(k / SQ_SIDE);
                rc.col = t_pos'(k % SQ_SIDE);
            end
        end
        return rc;
    endfunction

    function automatic t_letter cell_at(input t_square sq, input t_pos row, input t_pos col);
        t_letter v;
        v = '0;
        for (int k = 0; k < SQ_CELLS; k++) begin
            if (row == t_pos'(k / SQ_SIDE) && col == t_pos'(k % SQ_SIDE)) begin
                v = sq[k*LETTER_W +: LETTER_W];
            end
        end
        return v;
    endfunction

    function automatic t_pos step_fwd(input t_pos p);
        return (p == t_pos'(SQ_SIDE - 1)) ? '0 : t_pos'(p + 1'b1);
    endfunction

    function automatic t_pos step_back(input t_pos p);
        return (p == '0) ? t_pos'(SQ_SIDE - 1) : t_pos'(p - 1'b1);
    endfunction

endpackage

`default_nettype wire

FILE: design/pfc_subst.sv
// ============================================================================
// pfc_subst - Playfair substitution of one digraph
// Locates both letters in the key square and applies row, column or
// rectangle rule; shifts run backward when decrypting.
// ============================================================================
`default_nettype none

module pfc_subst (
    input  wire pfc_pkg::t_pair   i_pair,
    input  wire pfc_pkg::t_square i_square,
    input  wire                   i_decrypt,
    output pfc_pkg::t_subst       o_subst
);

    pfc_pkg::t_rowcol p1;
    pfc_pkg::t_rowcol p2;
    pfc_pkg::t_pos    r1_sh;
    pfc_pkg::t_pos    r2_sh;
    pfc_pkg::t_pos    c1_sh;
    pfc_pkg::t_pos    c2_sh;

    assign p1 = pfc_pkg::locate(i_square, i_pair.first);
    assign p2 = pfc_pkg::locate(i_square, i_pair.second);

    assign r1_sh = i_decrypt ? pfc_pkg::step_back(p1.row) : pfc_pkg::step_fwd(p1.row);
    assign r2_sh = i_decrypt ? pfc_pkg::step_back(p2.row) : pfc_pkg::step_fwd(p2.row);
    assign c1_sh = i_decrypt ? pfc_pkg::step_back(p1.col) : pfc_pkg::step_fwd(p1.col);
    assign c2_sh = i_decrypt ? pfc_pkg::step_back(p2.col) : pfc_pkg::step_fwd(p2.col);

    always_comb begin
        if (p1.row == p2.row) begin
            o_subst.o1 = pfc_pkg::cell_at(i_square, p1.row, c1_sh);
            o_subst.o2 = pfc_pkg::cell_at(i_square, p2.row, c2_sh);
        end else if (p1.col == p2.col) begin
            o_subst.o1 = pfc_pkg::cell_at(i_square, r1_sh, p1.col);
            o_subst.o2 = pfc_pkg::cell_at(i_square, r2_sh, p2.col);
        end else begin
            o_subst.o1 = pfc_pkg::cell_at(i_square, p1.row, p2.col);
            o_subst.o2 = pfc_pkg::cell_at(i_square, p2.row, p1.col);
        end
    end

endmodule

`default_nettype wire

FILE: design/playfair_digraph_cipher.sv
// ============================================================================
// playfair_digraph_cipher - streaming Playfair cipher over a 5x5 key square
// Letters in, substituted letters out, two per completed digraph.
// ============================================================================
// A request's first output letter passes the stage 1 and stage 2 registers.
// Throughput: one output letter per cycle while the receiver is ready, set by
//   the single output letter port; a request yields 0, 2 or 4 letters. Requests
//   that produce nothing leave stage 1 empty.
// Reset: synchronous active-low; clears mode, key square, waiting letter and
//   both pipeline stages.
`default_nettype none

module playfair_digraph_cipher (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write port
    input  wire                              i_cfg_we,
    input  wire [pfc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [pfc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input letters
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [pfc_pkg::TDATA_W-1:0]       s_axis_tdata,  // [4:0] letter_code, [7:5] zero
    input  wire                              s_axis_tlast,  // final_letter
    // output letters
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [pfc_pkg::TDATA_W-1:0]      m_axis_tdata,  // [4:0] out_letter, [7:5] zero
    output logic                             m_axis_tlast   // out_last
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                            r_decrypt;
    logic [pfc_pkg::PART_A_W-1:0]    r_part_a;
    logic [pfc_pkg::PART_B_W-1:0]    r_part_b;
    logic [pfc_pkg::PART_C_W-1:0]    r_part_c;
    pfc_pkg::t_square                square;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
            r_part_a  <= '0;
            r_part_b  <= '0;
            r_part_c  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfc_pkg::REG_DECRYPT: r_decrypt <= i_cfg_data[0];
                pfc_pkg::REG_PART_A:  r_part_a  <= i_cfg_data[pfc_pkg::PART_A_W-1:0];
                pfc_pkg::REG_PART_B:  r_part_b  <= i_cfg_data[pfc_pkg::PART_B_W-1:0];
                pfc_pkg::REG_PART_C:  r_part_c  <= i_cfg_data[pfc_pkg::PART_C_W-1:0];
            endcase
        end
    end

    // Cell 0 sits in the low bits, row-major upward.
    assign square = {r_part_c, r_part_b, r_part_a};

    // ------------------------------------------------------------------
    // Handshake plumbing
    // Stage 1 holds up to two digraphs from one request; stage 2 holds one
    // substituted digraph and sends its letters one per cycle while m_axis_tready is high.
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    logic             r_s1_two;
    logic             r_s1_idx;
    pfc_pkg::t_pair   r_p0;
    pfc_pkg::t_pair   r_p1;

    logic             r_s2_valid;
    logic             r_s2_sel;
    pfc_pkg::t_letter r_o1;
    pfc_pkg::t_letter r_o2;
    logic             r_s2_last;

    logic             s2_free;
    logic             s1_adv;
    logic             s1_done;
    logic             in_fire;
    logic             out_fire;

    assign out_fire      = r_s2_valid & m_axis_tready;
    // Stage 2 takes a new digraph once its second letter leaves.
    assign s2_free       = ~r_s2_valid | (out_fire & r_s2_sel);
    assign s1_adv        = r_s1_valid & s2_free;
    assign s1_done       = s1_adv & (~r_s1_two | r_s1_idx);
    assign s_axis_tready = ~r_s1_valid | s1_done;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    // ------------------------------------------------------------------
    // Pairing: decide which digraphs this request completes
    // ------------------------------------------------------------------
    logic             r_held_valid;
    pfc_pkg::t_letter r_held_letter;
    logic             n_held_valid;
    pfc_pkg::t_letter n_held_letter;

    pfc_pkg::t_letter raw_code;
    pfc_pkg::t_letter code;
    logic             is_space;
    logic             fin;
    logic             new_pair;
    logic             new_two;
    pfc_pkg::t_pair   new_p0;
    pfc_pkg::t_pair   new_p1;

    assign raw_code = s_axis_tdata[pfc_pkg::LETTER_W-1:0];
    assign is_space = raw_code >= pfc_pkg::CODE_SPACE;
    // Treat j as i.
    assign code     = (raw_code == pfc_pkg::CODE_J) ? pfc_pkg::CODE_I : raw_code;
    assign fin      = s_axis_tlast;

    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        new_pair      = 1'b0;
        new_two       = 1'b0;
        new_p0        = '{first: r_held_letter, second: pfc_pkg::CODE_FILLER, last: 1'b0};
        new_p1        = '{first: code, second: pfc_pkg::CODE_FILLER, last: 1'b1};
        if (is_space) begin
            // Drop spaces; a final space flushes a waiting letter padded with x.
            if (fin && r_held_valid) begin
                new_pair      = 1'b1;
                new_p0.last   = 1'b1;
                n_held_valid  = 1'b0;
                n_held_letter = '0;
            end
        end else if (!r_held_valid) begin
            if (fin) begin
                new_pair     = 1'b1;
                new_p0.first = code;
                new_p0.last  = 1'b1;
            end else begin
                n_held_valid  = 1'b1;
                n_held_letter = code;
            end
        end else if (!r_decrypt && r_held_letter == code) begin
            // Repeated letter: split with x, the second copy opens a new pair.
            new_pair = 1'b1;
            if (fin) begin
                new_two       = 1'b1;
                n_held_valid  = 1'b0;
                n_held_letter = '0;
            end
        end else begin
            new_pair      = 1'b1;
            new_p0.second = code;
            new_p0.last   = fin;
            n_held_valid  = 1'b0;
            n_held_letter = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_held_letter <= '0;
        end else if (in_fire) begin
            r_held_valid  <= n_held_valid;
            r_held_letter <= n_held_letter;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: digraph holding register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_two   <= 1'b0;
            r_s1_idx   <= 1'b0;
        end else if (in_fire && new_pair) begin
            r_s1_valid <= 1'b1;
            r_s1_two   <= new_two;
            r_s1_idx   <= 1'b0;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            // Advance to the second digraph of a split repeat.
            r_s1_idx <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && new_pair) begin
            r_p0 <= new_p0;
            r_p1 <= new_p1;
        end
    end

    // ------------------------------------------------------------------
    // Substitution and stage 2: result register and letter serializer
    // ------------------------------------------------------------------
    pfc_pkg::t_pair  cur_pair;
    pfc_pkg::t_subst subst;

    assign cur_pair = r_s1_idx ? r_p1 : r_p0;

    pfc_subst u_subst (
        .i_pair   (cur_pair),
        .i_square (square),
        .i_decrypt(r_decrypt),
        .o_subst  (subst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_sel   <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
            r_s2_sel   <= 1'b0;
        end else if (out_fire) begin
            if (r_s2_sel) begin
                r_s2_valid <= 1'b0;
            end else begin
                r_s2_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o1      <= subst.o1;
            r_o2      <= subst.o2;
            r_s2_last <= cur_pair.last;
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = {{(pfc_pkg::TDATA_W - pfc_pkg::LETTER_W){1'b0}},
                            (r_s2_sel ? r_o2 : r_o1)};
    // Only the second letter of a closing digraph carries last.
    assign m_axis_tlast  = r_s2_sel & r_s2_last;

endmodule

`default_nettype wire

FILE: tb/tb_playfair_digraph_cipher.sv
// ============================================================================
// tb_playfair_digraph_cipher - self-checking bench for the Playfair cipher
// Drives letter requests through the stream input, keeps a behavioral copy of
// the key square and the pairing state, and checks every output letter and
// its last flag in order. Runs a directed opener, then random messages over
// several key squares and both modes, with bursty input and output stalls.
// ============================================================================

module tb_playfair_digraph_cipher;

    import pfc_pkg::*;

    // One predicted output letter.
    typedef struct packed {
        t_letter letter;
        logic    last;
    } t_cipher_out;

    // Behavioral copy of the cipher: register shadows, the waiting letter and
    // the queue of letters the block still owes us.
    class playfair_tracker;
        bit                  decrypt;
        logic [PART_A_W-1:0] part_a;
        logic [PART_B_W-1:0] part_b;
        logic [PART_C_W-1:0] part_c;
        t_letter             held;
        bit                  held_ok;
        t_cipher_out         expected_letters[$];
        int                  fail_count;

        function new();
            decrypt    = 1'b0;
            part_a     = '0;
            part_b     = '0;
            part_c     = '0;
            held       = '0;
            held_ok    = 1'b0;
            fail_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DECRYPT: decrypt = data[0];
                REG_PART_A:  part_a  = data[PART_A_W-1:0];
                REG_PART_B:  part_b  = data[PART_B_W-1:0];
                REG_PART_C:  part_c  = data[PART_C_W-1:0];
                default: ;
            endcase
        endfunction

        function t_letter cell_value(t_square sq, int row, int col);
            return sq[(row * SQ_SIDE + col) * LETTER_W +: LETTER_W];
        endfunction

        // First match in row-major order; an absent letter sits at the corner.
        function int find_cell(t_square sq, t_letter letter);
            for (int k = 0; k < SQ_CELLS; k++) begin
                if (sq[k * LETTER_W +: LETTER_W] == letter)
                    return k;
            end
            return 0;
        endfunction

        function void substitute_pair(t_letter first, t_letter second, logic last);
            t_square sq;
            int      p1, p2, r1, c1, r2, c2, step;
            t_letter o1, o2;
            sq   = {part_c, part_b, part_a};
            p1   = find_cell(sq, first);
            p2   = find_cell(sq, second);
            r1   = p1 / SQ_SIDE;
            c1   = p1 % SQ_SIDE;
            r2   = p2 / SQ_SIDE;
            c2   = p2 % SQ_SIDE;
            step = decrypt ? SQ_SIDE - 1 : 1;
            if (r1 == r2) begin
                o1 = cell_value(sq, r1, (c1 + step) % SQ_SIDE);
                o2 = cell_value(sq, r2, (c2 + step) % SQ_SIDE);
            end else if (c1 == c2) begin
                o1 = cell_value(sq, (r1 + step) % SQ_SIDE, c1);
                o2 = cell_value(sq, (r2 + step) % SQ_SIDE, c2);
            end else begin
                o1 = cell_value(sq, r1, c2);
                o2 = cell_value(sq, r2, c1);
            end
            expected_letters.push_back(t_cipher_out'{o1, 1'b0});
            expected_letters.push_back(t_cipher_out'{o2, last});
        endfunction

        function void note_letter(logic [LETTER_W-1:0] code_in, logic fin);
            t_letter code;
            code = code_in;
            if (code >= CODE_SPACE) begin
                if (fin && held_ok) begin
                    substitute_pair(held, CODE_FILLER, 1'b1);
                    held_ok = 1'b0;
                    held    = '0;
                end
                return;
            end
            if (code == CODE_J)
                code = CODE_I;
            if (!held_ok) begin
                if (fin) begin
                    substitute_pair(code, CODE_FILLER, 1'b1);
                end else begin
                    held    = code;
                    held_ok = 1'b1;
                end
            end else if (!decrypt && held == code) begin
                substitute_pair(held, CODE_FILLER, 1'b0);
                if (fin) begin
                    substitute_pair(code, CODE_FILLER, 1'b1);
                    held_ok = 1'b0;
                    held    = '0;
                end
            end else begin
                substitute_pair(held, code, fin);
                held_ok = 1'b0;
                held    = '0;
            end
        endfunction

        function void check_output(logic [TDATA_W-1:0] data, logic last);
            t_cipher_out want;
            if (expected_letters.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected output: letter %0d last %0b", data, last);
                return;
            end
            want = expected_letters.pop_front();
            if (data !== TDATA_W'(want.letter) || last !== want.last) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("output mismatch: expected letter %0d last %0b, got letter %0d last %0b",
                             want.letter, want.last, data, last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block connections; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;   // [4:0] letter_code, [7:5] zero
    logic                  s_axis_tlast  = 1'b0; // final_letter
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;         // [4:0] out_letter, [7:5] zero
    logic                  m_axis_tlast;         // out_last

    playfair_tracker tracker;

    // Sender burst bookkeeping and receiver stall pattern.
    int burst_left = 0;
    int stall_style = 0;
    int stall_left = 0;

    playfair_digraph_cipher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the edge. Note the input request
    // first so its predicted letters are queued before any output is checked.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_letter(s_axis_tdata[LETTER_W-1:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_output(m_axis_tdata, m_axis_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: pick a new stall style whenever its countdown runs out -
    // always ready, coin toss, a fixed 3-of-4 pattern, and heavy backpressure.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (stall_left % 4) != 0;
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender: present one letter request and hold it until accepted. Requests
    // go out in bursts; between bursts drop valid for a random gap (or none).
    // ------------------------------------------------------------------------
    task automatic offer(input int code, input bit fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(code);
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Send a text; a blank becomes the space code. Optionally mark the end.
    task automatic send_text(input string text, input bit closes);
        int code;
        for (int n = 0; n < text.len(); n++) begin
            code = (text[n] == " ") ? int'(CODE_SPACE) : int'(text[n] - "a");
            offer(code, closes && (n == text.len() - 1));
        end
    endtask

    // Drop valid, wait for every owed letter, then let the pipe run dry:
    // a request that only loads the waiting letter leaves nothing to wait on.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_letters.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    // Write all four registers back to back, then drop the write enable once.
    task automatic load_config(input logic [CFG_DATA_W-1:0] mode_word,
                               input logic [CFG_DATA_W-1:0] word_a,
                               input logic [CFG_DATA_W-1:0] word_b,
                               input logic [CFG_DATA_W-1:0] word_c);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] words[4];
        idx   = '{REG_DECRYPT, REG_PART_A, REG_PART_B, REG_PART_C};
        words = '{mode_word, word_a, word_b, word_c};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= words[k];
            @(posedge i_clk);
            tracker.set_reg(idx[k], words[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random key square: the 25 letters without j, shuffled.
    function automatic t_square random_square();
        t_letter pool[SQ_CELLS];
        t_letter swap;
        t_square sq;
        int      n, pick;
        n = 0;
        for (int c = 0; c < 26; c++) begin
            if (c != CODE_J) begin
                pool[n] = t_letter'(c);
                n++;
            end
        end
        for (int k = SQ_CELLS - 1; k > 0; k--) begin
            pick       = $urandom_range(0, k);
            swap       = pool[k];
            pool[k]    = pool[pick];
            pool[pick] = swap;
        end
        for (int k = 0; k < SQ_CELLS; k++)
            sq[k * LETTER_W +: LETTER_W] = pool[k];
        return sq;
    endfunction

    // Random messages. Most are well formed: letters with frequent repeats,
    // some blanks and j, closed by a final request. The rest is noise over
    // the full 5-bit code range with random final flags. Count only letters.
    task automatic random_phase(input int quota);
        int sent, len, code, prev;
        bit noisy, fin;
        sent = 0;
        prev = 0;
        while (sent < quota) begin
            noisy = ($urandom_range(0, 6) == 0);
            len   = $urandom_range(1, 14);
            for (int n = 0; n < len; n++) begin
                if (noisy)
                    code = $urandom_range(0, 31);
                else if ($urandom_range(0, 3) == 0)
                    code = prev;
                else if ($urandom_range(0, 11) == 0)
                    code = CODE_SPACE;
                else if ($urandom_range(0, 15) == 0)
                    code = CODE_J;
                else
                    code = $urandom_range(0, 25);
                fin = noisy ? 1'($urandom_range(0, 1)) : (n == len - 1);
                offer(code, fin);
                if (code < CODE_SPACE) begin
                    sent++;
                    prev = code;
                end
            end
        end
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_square square;
        string   key_word;
        tracker  = new();
        key_word = "playfairexmbcdghknoqstuvwz";
        for (int k = 0; k < SQ_CELLS; k++)
            square[k * LETTER_W +: LETTER_W] = t_letter'(key_word[k] - "a");

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset square is all zeros: every letter maps to the corner cell.
        // A repeated pair splits with the filler, then a final pair closes.
        send_text("aaz", 1'b1);
        settle();

        // Keyword square, encrypt. Cover rectangle, column and row rules,
        // a blank and j read as i.
        load_config(CFG_DATA_W'(0), CFG_DATA_W'(square[PART_A_W-1:0]),
                    CFG_DATA_W'(square[PART_A_W +: PART_B_W]),
                    CFG_DATA_W'(square[PART_A_W + PART_B_W +: PART_C_W]));
        send_text("hide jeez", 1'b0);
        // Codes above the alphabet are dropped like a blank.
        offer(27, 1'b0);
        offer(31, 1'b0);
        // Doubled letter on the final request: four letters out.
        send_text("aa", 1'b1);
        // Final blank flushes a waiting letter; with none waiting, nothing.
        send_text("k ", 1'b1);
        send_text(" ", 1'b1);
        // Lone final letter gets padded.
        send_text("q", 1'b1);
        settle();

        // Same square, decrypt: pairs de and ez, column and rectangle rules.
        load_config(CFG_DATA_W'(1), CFG_DATA_W'(tracker.part_a),
                    CFG_DATA_W'(tracker.part_b), CFG_DATA_W'(tracker.part_c));
        send_text("deez", 1'b1);
        // Leave a letter waiting, flip to encrypt, then complete the pair.
        send_text("b", 1'b0);
        settle();
        load_config(CFG_DATA_W'(0), CFG_DATA_W'(tracker.part_a),
                    CFG_DATA_W'(tracker.part_b), CFG_DATA_W'(tracker.part_c));
        send_text("c", 1'b1);
        settle();

        // Random phases. Open with every register all ones, close with all
        // zeros; in between use shuffled squares or raw random register bits
        // (duplicate and missing letters). Phases may end mid-message.
        for (int p = 0; p < 6; p++) begin
            if (p == 0) begin
                load_config('1, '1, '1, '1);
            end else if (p == 5) begin
                load_config('0, '0, '0, '0);
            end else if ($urandom_range(0, 3) == 0) begin
                load_config(CFG_DATA_W'({$urandom, $urandom}),
                            CFG_DATA_W'({$urandom, $urandom}),
                            CFG_DATA_W'({$urandom, $urandom}),
                            CFG_DATA_W'({$urandom, $urandom}));
            end else begin
                square = random_square();
                load_config(CFG_DATA_W'($urandom_range(0, 1)),
                            CFG_DATA_W'(square[PART_A_W-1:0]),
                            CFG_DATA_W'(square[PART_A_W +: PART_B_W]),
                            CFG_DATA_W'(square[PART_A_W + PART_B_W +: PART_C_W]));
            end
            random_phase(28);
            settle();
        end

        if (tracker.fail_count == 0 && tracker.expected_letters.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
